// ===== hdl/tfpgl_pkg.sv =====
// Shared constants and types of the telemetry frame parser and gain loader.
package tfpgl_pkg;

  localparam int MAX_PAYLOAD_DEF = 49;
  localparam int GAIN_COUNT_DEF  = 9;
  localparam int CMD_DEPTH       = 2;

  localparam logic [7:0] SYNC_BYTE  = 8'hAA;
  localparam logic [7:0] SYNC2_BYTE = 8'hAF;
  localparam logic [7:0] FUNC_LIMIT = 8'hF1;
  localparam logic [7:0] FUNC_GAIN  = 8'h10;
  localparam logic [7:0] FUNC_READ  = 8'h02;
  localparam logic [7:0] READ_ARG   = 8'h01;
  localparam logic [7:0] ACK_ID     = 8'hEF;
  localparam logic [7:0] ACK_LEN    = 8'h02;
  localparam logic [7:0] DUMP_ID    = 8'h10;
  localparam int         ACK_BYTES  = 7;

  typedef enum logic {
    KIND_ACK  = 1'b0,
    KIND_DUMP = 1'b1
  } reply_kind_t;

  typedef struct packed {
    reply_kind_t kind;
    logic [7:0]  sum;
  } cmd_t;

endpackage

// ===== hdl/tfpgl_front.sv =====
// Frame parser: tracks the frame phase, stores payload bytes, loads gains, issues reply commands.
module tfpgl_front #(
  parameter int MAX_PAYLOAD = tfpgl_pkg::MAX_PAYLOAD_DEF,
  parameter int GAIN_COUNT  = tfpgl_pkg::GAIN_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_take,
  input  logic [7:0]              rx_byte,
  output logic                    cmd_wr,
  output tfpgl_pkg::cmd_t         cmd,
  output logic [16*GAIN_COUNT-1:0] cmd_gains
);

  localparam int StoreDepth = 2 * GAIN_COUNT;
  localparam int SIDX_W     = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int CNT_W      = $clog2(MAX_PAYLOAD + 1);
  localparam int GW         = 16 * GAIN_COUNT;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_SYNC2   = 6'b000010,
    PH_FUNC    = 6'b000100,
    PH_LEN     = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_CHECK   = 6'b100000
  } phase_t;

  phase_t            phase, phase_next;
  logic [7:0]        func, func_next;
  logic [CNT_W-1:0]  remaining, remaining_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [7:0]        sum, sum_next;
  logic [7:0]        store [StoreDepth];
  logic [7:0]        store_next [StoreDepth];
  logic [GW-1:0]     gains, gains_next;
  logic              store_we;
  logic              in_store;
  logic              load_gains;
  logic              is_ack;
  logic              is_dump;

  assign in_store = (CNT_W + 1)'(count) < (CNT_W + 1)'(StoreDepth);

  always_comb begin
    phase_next     = phase;
    func_next      = func;
    remaining_next = remaining;
    count_next     = count;
    sum_next       = sum;
    store_we       = 1'b0;
    load_gains     = 1'b0;
    is_ack         = 1'b0;
    is_dump        = 1'b0;
    if (in_take) begin
      unique case (phase)
        PH_IDLE: begin
          if (rx_byte == tfpgl_pkg::SYNC_BYTE) begin
            phase_next = PH_SYNC2;
            sum_next   = rx_byte;
          end
        end
        PH_SYNC2: begin
          if (rx_byte == tfpgl_pkg::SYNC2_BYTE) begin
            phase_next = PH_FUNC;
            sum_next   = sum + rx_byte;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_FUNC: begin
          if (rx_byte < tfpgl_pkg::FUNC_LIMIT) begin
            phase_next = PH_LEN;
            func_next  = rx_byte;
            sum_next   = sum + rx_byte;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_LEN: begin
          if ({1'b0, rx_byte} <= 9'(MAX_PAYLOAD)) begin
            phase_next     = PH_PAYLOAD;
            remaining_next = CNT_W'(rx_byte);
            count_next     = '0;
            sum_next       = sum + rx_byte;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_PAYLOAD: begin
          // A zero-length frame swallows the next byte and drops back to idle.
          if (remaining != '0) begin
            store_we       = in_store;
            count_next     = count + 1'b1;
            remaining_next = remaining - 1'b1;
            sum_next       = sum + rx_byte;
            if (remaining == CNT_W'(1)) begin
              phase_next = PH_CHECK;
            end
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_CHECK: begin
          // The check byte lands in the store too when its position fits.
          phase_next = PH_IDLE;
          store_we   = in_store;
          if (func == tfpgl_pkg::FUNC_GAIN) begin
            load_gains = 1'b1;
            is_ack     = 1'b1;
          end else if (func == tfpgl_pkg::FUNC_READ) begin
            is_dump = 1'b1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < StoreDepth; i++) begin
      store_next[i] = store[i];
    end
    if (store_we) begin
      store_next[count[SIDX_W-1:0]] = rx_byte;
    end
  end

  // Gain 0 sits in the top bits so the dump can shift bytes out in order.
  always_comb begin
    gains_next = gains;
    if (load_gains) begin
      for (int i = 0; i < StoreDepth; i++) begin
        gains_next[GW-1-8*i -: 8] = store_next[i];
      end
    end
  end

  assign cmd_wr    = is_ack || (is_dump && store_next[0] == tfpgl_pkg::READ_ARG);
  assign cmd.kind  = is_dump ? tfpgl_pkg::KIND_DUMP : tfpgl_pkg::KIND_ACK;
  assign cmd.sum   = sum;
  assign cmd_gains = gains_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      func      <= '0;
      remaining <= '0;
      count     <= '0;
      sum       <= '0;
      gains     <= '0;
      for (int i = 0; i < StoreDepth; i++) begin
        store[i] <= '0;
      end
    end else begin
      phase     <= phase_next;
      func      <= func_next;
      remaining <= remaining_next;
      count     <= count_next;
      sum       <= sum_next;
      gains     <= gains_next;
      for (int i = 0; i < StoreDepth; i++) begin
        store[i] <= store_next[i];
      end
    end
  end

  a_cmd_only_on_check: assert property (@(posedge clk) disable iff (rst)
    cmd_wr |-> (in_take && phase == PH_CHECK))
    else $error("reply command issued outside the check byte");

  a_payload_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> ((CNT_W + 1)'(count) + (CNT_W + 1)'(remaining)
                               <= (CNT_W + 1)'(MAX_PAYLOAD)))
    else $error("payload count exceeds the frame length limit");

endmodule

// ===== hdl/tfpgl_cmd_fifo.sv =====
// Short command queue between the frame parser and the reply sequencer.
module tfpgl_cmd_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = tfpgl_pkg::CMD_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full      = fill == CNT_W'(DEPTH);
  assign not_empty = fill != '0;
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(wr_en && full))
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(rd_en && !not_empty))
    else $error("command queue read while empty");

endmodule

// ===== hdl/tfpgl_back.sv =====
// Reply sequencer: turns one queued command into an ack or gain dump, one word per cycle while pop drains.
module tfpgl_back #(
  parameter int GAIN_COUNT = tfpgl_pkg::GAIN_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_avail,
  input  tfpgl_pkg::cmd_t          cmd,
  input  logic [16*GAIN_COUNT-1:0] cmd_gains,
  output logic                     cmd_take,
  output logic                     empty,
  input  logic                     pop,
  output logic [7:0]               tx_byte,
  output logic                     tx_last,
  output logic                     reply_kind
);

  localparam int GW         = 16 * GAIN_COUNT;
  localparam int StoreDepth = 2 * GAIN_COUNT;
  localparam int DumpLen    = StoreDepth + 5;
  localparam int IDX_W      = $clog2(DumpLen);

  logic                   busy;
  tfpgl_pkg::reply_kind_t kind;
  logic [7:0]             sum;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       last_idx;
  logic [GW-1:0]          shreg;
  logic [7:0]             chk;
  logic                   out_valid;
  logic                   advance;
  logic [7:0]             byte_now;
  logic                   last_now;
  logic                   shift_now;

  assign advance  = busy && (!out_valid || pop);
  assign cmd_take = !busy && cmd_avail;
  assign empty    = !out_valid;
  assign last_idx = (kind == tfpgl_pkg::KIND_DUMP) ? IDX_W'(DumpLen - 1)
                                                   : IDX_W'(tfpgl_pkg::ACK_BYTES - 1);

  always_comb begin
    byte_now  = chk;
    last_now  = 1'b0;
    shift_now = 1'b0;
    if (idx == last_idx) begin
      last_now = 1'b1;
    end else if (idx < IDX_W'(2)) begin
      byte_now = tfpgl_pkg::SYNC_BYTE;
    end else if (kind == tfpgl_pkg::KIND_ACK) begin
      unique case (idx)
        IDX_W'(2): byte_now = tfpgl_pkg::ACK_ID;
        IDX_W'(3): byte_now = tfpgl_pkg::ACK_LEN;
        IDX_W'(4): byte_now = tfpgl_pkg::FUNC_GAIN;
        default:   byte_now = sum;
      endcase
    end else if (idx == IDX_W'(2)) begin
      byte_now = tfpgl_pkg::DUMP_ID;
    end else if (idx == IDX_W'(3)) begin
      byte_now = 8'(StoreDepth);
    end else begin
      byte_now  = shreg[GW-1 -: 8];
      shift_now = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      kind  <= cmd.kind;
      sum   <= cmd.sum;
      shreg <= cmd_gains;
      idx   <= '0;
      chk   <= '0;
    end else if (advance) begin
      idx <= idx + 1'b1;
      chk <= chk + byte_now;
      if (shift_now) begin
        shreg <= {shreg[GW-9:0], 8'h00};
      end
    end
    if (advance) begin
      tx_byte    <= byte_now;
      tx_last    <= last_now;
      reply_kind <= kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_take) begin
        busy <= 1'b1;
      end else if (advance && last_now) begin
        busy <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_last_ends_reply: assert property (@(posedge clk) disable iff (rst)
    (advance && last_now) |=> !busy)
    else $error("sequencer still busy after the final word");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= last_idx)
    else $error("reply index ran past the final word");

endmodule

// ===== hdl/telemetry_frame_parser_gain_loader.sv =====
// Parses AA AF framed telemetry bytes, loads gain words on function 10 frames and answers with
// an ack (7 words) or, on function 02 with argument 01, a gain dump (2*GAIN_COUNT+5 words).
// Each received word is taken while full is low; a finished gain frame, or read frame with
// argument 01, places one reply command into a two-entry queue, and the reply sequencer then
// streams one reply word per cycle to the output register while pop keeps it drained. full
// rises only while both queue entries hold unstarted replies; only then does input stall.
module telemetry_frame_parser_gain_loader #(
  parameter int MAX_PAYLOAD = tfpgl_pkg::MAX_PAYLOAD_DEF,
  parameter int GAIN_COUNT  = tfpgl_pkg::GAIN_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] tx_byte,
  output logic       tx_last,
  output logic       reply_kind
);

  localparam int GW    = 16 * GAIN_COUNT;
  localparam int CMD_W = $bits(tfpgl_pkg::cmd_t);

  logic                  in_take;
  logic                  cmd_wr;
  tfpgl_pkg::cmd_t       front_cmd;
  logic [GW-1:0]         front_gains;
  logic [CMD_W+GW-1:0]   q_data;
  logic                  q_full;
  logic                  q_avail;
  logic                  cmd_take;
  tfpgl_pkg::cmd_t       back_cmd;
  logic [GW-1:0]         back_gains;

  assign full    = q_full;
  assign in_take = push && !q_full;

  tfpgl_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .GAIN_COUNT  (GAIN_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_take   (in_take),
    .rx_byte   (rx_byte),
    .cmd_wr    (cmd_wr),
    .cmd       (front_cmd),
    .cmd_gains (front_gains)
  );

  tfpgl_cmd_fifo #(
    .W     (CMD_W + GW),
    .DEPTH (tfpgl_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cmd_wr),
    .wr_data   ({front_cmd, front_gains}),
    .rd_en     (cmd_take),
    .rd_data   (q_data),
    .full      (q_full),
    .not_empty (q_avail)
  );

  assign back_cmd   = q_data[CMD_W+GW-1 -: CMD_W];
  assign back_gains = q_data[GW-1:0];

  tfpgl_back #(
    .GAIN_COUNT (GAIN_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_avail  (q_avail),
    .cmd        (back_cmd),
    .cmd_gains  (back_gains),
    .cmd_take   (cmd_take),
    .empty      (empty),
    .pop        (pop),
    .tx_byte    (tx_byte),
    .tx_last    (tx_last),
    .reply_kind (reply_kind)
  );

endmodule
